[hw/rtl/fp64_add_sub_mul_div_unit_defines.svh]
// Assertion helpers shared by the RTL. Each macro expects clk and rst_n in scope.
`ifndef FP64_ADD_SUB_MUL_DIV_UNIT_DEFINES_SVH
`define FP64_ADD_SUB_MUL_DIV_UNIT_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define FP64U_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fp64u check failed");

// Next-cycle implication, checked while out of reset.
`define FP64U_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fp64u check failed");

`endif

[hw/rtl/fp64u_pkg.sv]
// ----------------------------------------------------------------------------
// fp64u_pkg
// Types and constants shared by the binary64 add/sub/mul/div pipeline.
// ----------------------------------------------------------------------------
package fp64u_pkg;

    localparam logic [63:0] QNAN_BITS = 64'h7ff8000000000000;
    localparam logic [62:0] INF_MAG   = 63'h7ff0000000000000;
    localparam logic [63:0] SIGN_MASK = 64'h8000000000000000;

    localparam int NUM_CELLS = 57;
    localparam int ACC_W     = 110;
    localparam int SIG_W     = 57;
    localparam int EXP_W     = 14;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef logic signed [EXP_W-1:0] exp_t;

    localparam exp_t EXP_BIAS    = 14'sd1023;
    localparam exp_t EXP_MAX     = 14'sd2047;
    localparam exp_t EXP_SUB_MIN = -14'sd1022;

    // Request payload as it travels down the cell chain.
    typedef struct packed {
        op_t                op;
        logic               sign;
        exp_t               expo;
        logic               special;
        logic [63:0]        spec_val;
        logic [52:0]        divisor;
        logic [ACC_W-1:0]   acc;
        logic [SIG_W-1:0]   qm;
    } cell_t;

endpackage

[hw/rtl/fp64u_front.sv]
// ----------------------------------------------------------------------------
// fp64u_front
// Unpacks both operands, resolves special cases, aligns and adds for
// add/subtract, and loads the iterative cells for multiply and divide.
// ----------------------------------------------------------------------------
`include "fp64_add_sub_mul_div_unit_defines.svh"
module fp64u_front
    import fp64u_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [1:0]  op,
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    output logic        out_valid,
    output cell_t       out_data
);

    typedef enum logic [1:0] {
        CLS_ZERO,
        CLS_INF,
        CLS_NAN,
        CLS_FIN
    } cls_t;

    typedef struct packed {
        logic        sign;
        cls_t        cls;
        exp_t        e;
        logic [52:0] m;
    } operand_t;

    function automatic operand_t unpack_op(input logic [63:0] bits);
        operand_t    r;
        logic [10:0] be;
        logic [51:0] f;
        logic [5:0]  msb;
        logic [5:0]  sh;
        be  = bits[62:52];
        f   = bits[51:0];
        msb = '0;
        for (int i = 0; i < 52; i++)
        begin
            if (f[i])
            begin
                msb = 6'(i);
            end
        end
        sh     = 6'd52 - msb;
        r.sign = bits[63];
        r.e    = '0;
        r.m    = '0;
        r.cls  = CLS_FIN;
        if (be == 11'h7ff)
        begin
            r.cls = (f != '0) ? CLS_NAN : CLS_INF;
        end
        else if (be == 11'd0)
        begin
            if (f == '0)
            begin
                r.cls = CLS_ZERO;
            end
            else
            begin
                r.m = 53'(f) << sh;
                r.e = EXP_SUB_MIN - exp_t'({8'd0, sh});
            end
        end
        else
        begin
            r.e = exp_t'({3'd0, be}) - EXP_BIAS;
            r.m = {1'b1, f};
        end
        return r;
    endfunction

    // Stage 1 signals
    op_t         op_in;
    logic [63:0] b_eff;
    operand_t    ua;
    operand_t    ub;
    logic        sxor;
    logic        spec_c;
    logic [63:0] sval_c;

    logic        v1_reg;
    op_t         op1_reg;
    operand_t    ua1_reg;
    operand_t    ub1_reg;
    logic        spec1_reg;
    logic [63:0] sval1_reg;

    // Stage 2 signals
    logic        swap;
    exp_t        big_e;
    exp_t        small_e;
    logic [52:0] big_m;
    logic [52:0] small_m;
    logic        big_s;
    logic        small_s;
    exp_t        diff_e;
    logic [55:0] ms;
    logic [55:0] mg;
    logic [55:0] sm;
    logic [5:0]  dsh;
    logic        lost;
    logic [56:0] mant;
    logic        add_sign;
    cell_t       nxt;

    logic        v2_reg;
    cell_t       data2_reg;

    assign op_in = op_t'(op);
    assign b_eff = (op_in == OP_SUB) ? (operand_b ^ SIGN_MASK) : operand_b;
    assign ua    = unpack_op(operand_a);
    assign ub    = unpack_op(b_eff);
    assign sxor  = ua.sign ^ ub.sign;

    always_comb
    begin
        spec_c = 1'b1;
        sval_c = QNAN_BITS;
        case (op_in)
            OP_ADD, OP_SUB:
            begin
                if (ua.cls == CLS_NAN || ub.cls == CLS_NAN)
                    sval_c = QNAN_BITS;
                else if (ua.cls == CLS_INF || ub.cls == CLS_INF)
                begin
                    if (ua.cls == CLS_INF && ub.cls == CLS_INF && sxor)
                        sval_c = QNAN_BITS;
                    else
                        sval_c = (ua.cls == CLS_INF) ? operand_a : b_eff;
                end
                else if (ua.cls == CLS_ZERO && ub.cls == CLS_ZERO)
                    sval_c = {ua.sign & ub.sign, 63'd0};
                else if (ua.cls == CLS_ZERO)
                    sval_c = b_eff;
                else if (ub.cls == CLS_ZERO)
                    sval_c = operand_a;
                else
                    spec_c = 1'b0;
            end
            OP_MUL:
            begin
                if (ua.cls == CLS_NAN || ub.cls == CLS_NAN)
                    sval_c = QNAN_BITS;
                else if (ua.cls == CLS_INF || ub.cls == CLS_INF)
                begin
                    if (ua.cls == CLS_ZERO || ub.cls == CLS_ZERO)
                        sval_c = QNAN_BITS;
                    else
                        sval_c = {sxor, INF_MAG};
                end
                else if (ua.cls == CLS_ZERO || ub.cls == CLS_ZERO)
                    sval_c = {sxor, 63'd0};
                else
                    spec_c = 1'b0;
            end
            default:
            begin
                if (ua.cls == CLS_NAN || ub.cls == CLS_NAN)
                    sval_c = QNAN_BITS;
                else if (ua.cls == CLS_INF && ub.cls == CLS_INF)
                    sval_c = QNAN_BITS;
                else if (ua.cls == CLS_INF)
                    sval_c = {sxor, INF_MAG};
                else if (ub.cls == CLS_INF)
                    sval_c = {sxor, 63'd0};
                else if (ub.cls == CLS_ZERO)
                    sval_c = (ua.cls == CLS_ZERO) ? QNAN_BITS : {sxor, INF_MAG};
                else if (ua.cls == CLS_ZERO)
                    sval_c = {sxor, 63'd0};
                else
                    spec_c = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        op1_reg   <= op_in;
        ua1_reg   <= ua;
        ub1_reg   <= ub;
        spec1_reg <= spec_c;
        sval1_reg <= sval_c;
        data2_reg <= nxt;
    end

    // Alignment and magnitude add for add/subtract.
    always_comb
    begin
        swap    = ua1_reg.e < ub1_reg.e;
        big_e   = swap ? ub1_reg.e : ua1_reg.e;
        small_e = swap ? ua1_reg.e : ub1_reg.e;
        big_m   = swap ? ub1_reg.m : ua1_reg.m;
        small_m = swap ? ua1_reg.m : ub1_reg.m;
        big_s   = swap ? ub1_reg.sign : ua1_reg.sign;
        small_s = swap ? ua1_reg.sign : ub1_reg.sign;
        diff_e  = big_e - small_e;
        ms      = {small_m, 3'b000};
        mg      = {big_m, 3'b000};
        dsh     = diff_e[5:0];
        lost    = |(ms & ((56'd1 << dsh) - 56'd1));
        if (diff_e > 14'sd55)
            sm = 56'(ms != '0);
        else
            sm = (ms >> dsh) | 56'(lost);
        add_sign = big_s;
        if (big_s == small_s)
            mant = {1'b0, mg} + {1'b0, sm};
        else if (mg >= sm)
            mant = 57'(mg - sm);
        else
        begin
            mant     = 57'(sm - mg);
            add_sign = small_s;
        end
    end

    always_comb
    begin
        nxt.op       = op1_reg;
        nxt.special  = spec1_reg;
        nxt.spec_val = sval1_reg;
        nxt.divisor  = ub1_reg.m;
        nxt.sign     = ua1_reg.sign ^ ub1_reg.sign;
        nxt.acc      = '0;
        nxt.qm       = '0;
        nxt.expo     = ua1_reg.e + ub1_reg.e;
        case (op1_reg)
            OP_MUL:
            begin
                nxt.qm = {ua1_reg.m, 4'b0000};
            end
            OP_DIV:
            begin
                nxt.acc  = ACC_W'(ua1_reg.m);
                nxt.expo = ua1_reg.e - ub1_reg.e - 14'sd1;
            end
            default:
            begin
                nxt.qm   = mant;
                nxt.sign = add_sign;
                nxt.expo = big_e;
                // Exact cancellation gives positive zero.
                if (!spec1_reg && mant == '0)
                begin
                    nxt.special  = 1'b1;
                    nxt.spec_val = '0;
                end
            end
        endcase
    end

    assign out_valid = v2_reg;
    assign out_data  = data2_reg;

    `FP64U_ASSERT_NXT(a_front_stage1, in_valid, v1_reg)
    `FP64U_ASSERT_NXT(a_front_stage2, v1_reg, out_valid)
    `FP64U_ASSERT_IMP(a_front_nan_special,
        v1_reg && (ua1_reg.cls == CLS_NAN || ub1_reg.cls == CLS_NAN),
        spec1_reg && sval1_reg == QNAN_BITS)

endmodule

[hw/rtl/fp64u_cell.sv]
// ----------------------------------------------------------------------------
// fp64u_cell
// One step of the iterative chain: a shift-add multiply step, a restoring
// divide step, or a plain hand-on for add/subtract requests.
// ----------------------------------------------------------------------------
`include "fp64_add_sub_mul_div_unit_defines.svh"
module fp64u_cell
    import fp64u_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  cell_t in_data,
    output logic  out_valid,
    output cell_t out_data
);

    logic        valid_reg;
    cell_t       data_reg;
    cell_t       data_next;
    logic [53:0] rem;
    logic [53:0] dvs;
    logic        ge;
    logic [53:0] rdiff;

    assign rem   = in_data.acc[53:0];
    assign dvs   = {1'b0, in_data.divisor};
    assign ge    = rem >= dvs;
    assign rdiff = ge ? (rem - dvs) : rem;

    always_comb
    begin
        data_next = in_data;
        case (in_data.op)
            OP_MUL:
            begin
                data_next.acc = {in_data.acc[ACC_W-2:0], 1'b0}
                              + (in_data.qm[SIG_W-1] ? ACC_W'(in_data.divisor) : '0);
                data_next.qm  = {in_data.qm[SIG_W-2:0], 1'b0};
            end
            OP_DIV:
            begin
                // The partial remainder stays below the divisor after the subtract.
                data_next.acc = ACC_W'({rdiff[52:0], 1'b0});
                data_next.qm  = {in_data.qm[SIG_W-2:0], ge};
            end
            default:
            begin
                data_next = in_data;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    `FP64U_ASSERT_NXT(a_cell_forward, in_valid, out_valid)
    `FP64U_ASSERT_IMP(a_cell_origin, out_valid, $past(in_valid))
    `FP64U_ASSERT_IMP(a_cell_add_hold,
        out_valid && (out_data.op == OP_ADD || out_data.op == OP_SUB),
        out_data.qm == $past(in_data.qm))

endmodule

[hw/rtl/fp64u_round.sv]
// ----------------------------------------------------------------------------
// fp64u_round
// Forms the sticky significand, normalises it, then rounds to nearest even
// and packs the binary64 result, including subnormals and overflow.
// ----------------------------------------------------------------------------
`include "fp64_add_sub_mul_div_unit_defines.svh"
module fp64u_round
    import fp64u_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  cell_t       in_data,
    output logic        done,
    output logic [63:0] result_bits
);

    // Normalise stage
    logic [SIG_W-1:0] sig;
    logic [5:0]       msb;
    logic [5:0]       lsh;
    logic [55:0]      nsig;
    exp_t             ne;

    logic             va_reg;
    logic             spec_a_reg;
    logic [63:0]      sval_a_reg;
    logic             sign_a_reg;
    exp_t             be_a_reg;
    logic [55:0]      sig_a_reg;

    // Round stage
    exp_t             be;
    exp_t             nsh;
    logic [5:0]       nn;
    logic [63:0]      wide;
    logic             lost;
    logic [55:0]      s;
    logic [52:0]      frac;
    logic [2:0]       grs;
    logic             up;
    logic [53:0]      fr1;
    logic [52:0]      fr;
    logic [63:0]      res_c;

    logic             done_reg;
    logic [63:0]      result_reg;

    always_comb
    begin
        case (in_data.op)
            OP_MUL:
                sig = in_data.acc[ACC_W-1:53] | SIG_W'(in_data.acc[52:0] != '0);
            OP_DIV:
                sig = in_data.qm | SIG_W'(in_data.acc != '0);
            default:
                sig = in_data.qm;
        endcase
        msb = '0;
        for (int i = 0; i < 56; i++)
        begin
            if (sig[i])
            begin
                msb = 6'(i);
            end
        end
        lsh = 6'd55 - msb;
        if (sig[SIG_W-1])
        begin
            nsig = {sig[56:2], sig[1] | sig[0]};
            ne   = in_data.expo + 14'sd1;
        end
        else
        begin
            nsig = sig[55:0] << lsh;
            ne   = in_data.expo - exp_t'({8'd0, lsh});
        end
    end

    always_comb
    begin
        be   = be_a_reg;
        s    = sig_a_reg;
        nsh  = 14'sd1 - be_a_reg;
        nn   = nsh[5:0];
        wide = {8'd0, sig_a_reg};
        lost = |(wide & ((64'd1 << nn) - 64'd1));
        if (be_a_reg <= 14'sd0)
        begin
            // Subnormal range: denormalise with everything lost folded into sticky.
            if (nsh > 14'sd63)
                s = 56'd1;
            else
                s = 56'(wide >> nn) | 56'(lost);
            be = '0;
        end
        frac = s[55:3];
        grs  = s[2:0];
        up   = (grs > 3'd4) || (grs == 3'd4 && frac[0]);
        fr1  = {1'b0, frac} + 54'(up);
        fr   = frac;
        if (fr1[53])
        begin
            fr = fr1[53:1];
            be = be + 14'sd1;
        end
        else
        begin
            fr = fr1[52:0];
        end
        if (be == 14'sd0 && fr[52])
            be = 14'sd1;
        if (spec_a_reg)
            res_c = sval_a_reg;
        else if (be_a_reg >= EXP_MAX || be >= EXP_MAX)
            res_c = {sign_a_reg, INF_MAG};
        else
            res_c = {sign_a_reg, be[10:0], fr[51:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            va_reg   <= in_valid;
            done_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        spec_a_reg <= in_data.special;
        sval_a_reg <= in_data.spec_val;
        sign_a_reg <= in_data.sign;
        be_a_reg   <= ne + EXP_BIAS;
        sig_a_reg  <= nsig;
        result_reg <= res_c;
    end

    assign done        = done_reg;
    assign result_bits = result_reg;

    `FP64U_ASSERT_NXT(a_round_forward, va_reg, done)
    `FP64U_ASSERT_IMP(a_round_origin, done, $past(in_valid, 2))
    `FP64U_ASSERT_IMP(a_round_nan_canon,
        done && result_bits[62:52] == 11'h7ff && result_bits[51:0] != '0,
        result_bits == QNAN_BITS)

endmodule

[hw/rtl/fp64_add_sub_mul_div_unit.sv]
// ----------------------------------------------------------------------------
// fp64_add_sub_mul_div_unit
// IEEE-754 binary64 add, subtract, multiply and divide, round to nearest even.
// ----------------------------------------------------------------------------
//  Channel   Signals                        Direction  Transfer
//  request   start, op, operand_a/_b, busy  in         start && !busy
//  result    done, result_bits              out        done, one cycle
//
//  A request is taken in every cycle; busy is never raised.
//  Each request passes through the unpack and align stages, then 57 cells
//  of the shift-add/restoring-divide chain, then the normalise and round
//  stages. The divide's 57 quotient bits set the length of that chain.
//  Results leave in request order; the receiver cannot stall them.
//  Reset clears all valid flags; requests in flight are dropped.
// ----------------------------------------------------------------------------
module fp64_add_sub_mul_div_unit
    import fp64u_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    output logic        done,
    output logic [63:0] result_bits
);

    logic  chain_valid [0:NUM_CELLS];
    cell_t chain_data  [0:NUM_CELLS];

    assign busy = 1'b0;

    fp64u_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .op        (op),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0])
    );

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        fp64u_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    fp64u_round u_round (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (chain_valid[NUM_CELLS]),
        .in_data     (chain_data[NUM_CELLS]),
        .done        (done),
        .result_bits (result_bits)
    );

endmodule
